// ===== rtl/rmecc_pkg.sv =====
// ============================================================================
// rmecc_pkg - shared types and constants of the RGB colour classifier
// Word formats, register indexes, colour codes, grades and sequencer states.
// ============================================================================
package rmecc_pkg;

    // Sample and filter widths
    localparam int SAMPLE_BITS = 10;
    localparam int ALPHA_BITS  = 9;
    localparam int ALPHA_FRAC  = 8;
    localparam int THRESH_BITS = 10;
    localparam int CODE_BITS   = 4;
    localparam int ACC_BITS    = ALPHA_BITS + SAMPLE_BITS + 1;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(256);

    // Configuration port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_ALPHA     = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_LOW_THR   = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_HIGH_THR  = 2'd2;

    localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET    = 9'd128;
    localparam logic [THRESH_BITS-1:0] LOW_THR_RESET  = 10'd256;
    localparam logic [THRESH_BITS-1:0] HIGH_THR_RESET = 10'd768;

    // Colour codes
    localparam logic [CODE_BITS-1:0] COLOR_WHITE   = 4'd0;
    localparam logic [CODE_BITS-1:0] COLOR_BLACK   = 4'd1;
    localparam logic [CODE_BITS-1:0] COLOR_BLUE    = 4'd2;
    localparam logic [CODE_BITS-1:0] COLOR_RED     = 4'd3;
    localparam logic [CODE_BITS-1:0] COLOR_GREEN   = 4'd4;
    localparam logic [CODE_BITS-1:0] COLOR_YELLOW  = 4'd5;
    localparam logic [CODE_BITS-1:0] COLOR_MAGENTA = 4'd6;
    localparam logic [CODE_BITS-1:0] COLOR_CYAN    = 4'd7;
    localparam logic [CODE_BITS-1:0] COLOR_UNKNOWN = 4'd8;

    // Channel indexes of the sequencer
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        GRADE_LOW,
        GRADE_MED,
        GRADE_HIGH
    } grade_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RANK,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_STORE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red_sample;
        logic [SAMPLE_BITS-1:0] green_sample;
        logic [SAMPLE_BITS-1:0] blue_sample;
    } sample_word_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]   color_code;
        logic [SAMPLE_BITS-1:0] filtered_red;
        logic [SAMPLE_BITS-1:0] filtered_green;
        logic [SAMPLE_BITS-1:0] filtered_blue;
    } result_word_t;

    // Grade one filtered value; the low test wins when the thresholds cross
    function automatic grade_t grade_of(
        input logic [SAMPLE_BITS-1:0] v,
        input logic [THRESH_BITS-1:0] lo,
        input logic [THRESH_BITS-1:0] hi
    );
        grade_t g;
        priority if (v < lo) begin
            g = GRADE_LOW;
        end else if (v > hi) begin
            g = GRADE_HIGH;
        end else begin
            g = GRADE_MED;
        end
        return g;
    endfunction

    // Map the three grades to a colour code
    function automatic logic [CODE_BITS-1:0] classify(
        input grade_t r,
        input grade_t g,
        input grade_t b
    );
        logic [CODE_BITS-1:0] code;
        priority if (r == GRADE_HIGH && g == GRADE_HIGH && b == GRADE_HIGH) begin
            code = COLOR_WHITE;
        end else if (r == GRADE_LOW && g == GRADE_LOW && b == GRADE_LOW) begin
            code = COLOR_BLACK;
        end else if (r == GRADE_LOW && g == GRADE_LOW && b == GRADE_HIGH) begin
            code = COLOR_BLUE;
        end else if (r == GRADE_HIGH && g == GRADE_LOW && b == GRADE_LOW) begin
            code = COLOR_RED;
        end else if (r == GRADE_LOW && g == GRADE_HIGH && b == GRADE_LOW) begin
            code = COLOR_GREEN;
        end else if (r == GRADE_HIGH && g == GRADE_HIGH && b == GRADE_LOW) begin
            code = COLOR_YELLOW;
        end else if (r == GRADE_HIGH && g == GRADE_LOW && b == GRADE_HIGH) begin
            code = COLOR_MAGENTA;
        end else if (r == GRADE_LOW && g == GRADE_HIGH && b == GRADE_HIGH) begin
            code = COLOR_CYAN;
        end else begin
            code = COLOR_UNKNOWN;
        end
        return code;
    endfunction

endpackage

// ===== rtl/rgb_median_ema_color_classifier_core.sv =====
// ============================================================================
// rgb_median_ema_color_classifier_core - median, smoothing and colour grading
// Collects a window of RGB samples, takes each channel's median with a shared
// rank unit, smooths it with an exponential filter on a shared multiplier and
// grades the three filtered values into a colour code.
// ============================================================================
//
//  channel   ports                          word            direction
//  -------   -----------------------------  --------------  ---------
//  sample    s_valid / s_ready / s_data     sample_word_t   in
//  result    m_valid / m_ready / m_data     result_word_t   out
//  config    psel penable pwrite paddr ...  32-bit APB      in / out
//
//  A sample that does not complete the window is taken while the core is idle.
//  The sample that completes it starts a run that ends when the result
//  word is loaded: per channel one load, one rank step per window entry
//  on the shared comparator row, two passes of the shared multiplier and
//  one store. s_ready stays low during that run.
//  A result word waits in the output register; the run stalls at its end
//  only if the previous word has not been taken.
//  Reset (aresetn low, synchronous) empties the window and clears the
//  filter history and registers to their defaults; no clearing pass.
//
module rgb_median_ema_color_classifier_core #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // sample channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  rmecc_pkg::sample_word_t                 s_data,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output rmecc_pkg::result_word_t                 m_data,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rmecc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [rmecc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [rmecc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                    pready
);
    import rmecc_pkg::*;

    localparam int FILL_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int K_LO   = (WINDOW_SIZE - 1) / 2;
    localparam int K_HI   = WINDOW_SIZE / 2;
    localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(WINDOW_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ALPHA_BITS-1:0]   alpha_reg;
    logic [THRESH_BITS-1:0]  low_thr_reg;
    logic [THRESH_BITS-1:0]  high_thr_reg;
    logic [REG_IDX_BITS-1:0] cfg_idx;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Write a register on the access cycle; ignore unmapped addresses
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= ALPHA_RESET;
            low_thr_reg  <= LOW_THR_RESET;
            high_thr_reg <= HIGH_THR_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_ALPHA:    alpha_reg    <= pwdata[ALPHA_BITS-1:0];
                REG_LOW_THR:  low_thr_reg  <= pwdata[THRESH_BITS-1:0];
                REG_HIGH_THR: high_thr_reg <= pwdata[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (cfg_idx)
            REG_ALPHA:    prdata = APB_DATA_BITS'(alpha_reg);
            REG_LOW_THR:  prdata = APB_DATA_BITS'(low_thr_reg);
            REG_HIGH_THR: prdata = APB_DATA_BITS'(high_thr_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and datapath state
    // ------------------------------------------------------------------
    ctrl_state_t            state_reg, state_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      idx_reg, idx_next;
    logic [1:0]             ch_reg, ch_next;
    logic                   m_valid_reg, m_valid_next;

    logic [SAMPLE_BITS-1:0] win_red_reg   [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] win_green_reg [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] win_blue_reg  [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] work_reg      [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] med_lo_reg;
    logic [SAMPLE_BITS-1:0] med_hi_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic [SAMPLE_BITS-1:0] prev_reg [3];
    result_word_t           res_reg;

    logic s_fire;
    logic do_load, do_rank, do_mul_new, do_mul_old, do_store, do_emit;

    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    // Sequence the shared units: next state and strobes
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        ch_next      = ch_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        do_load      = 1'b0;
        do_rank      = 1'b0;
        do_mul_new   = 1'b0;
        do_mul_old   = 1'b0;
        do_store     = 1'b0;
        do_emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (fill_reg == LAST_SLOT) begin
                        fill_next  = '0;
                        ch_next    = CH_RED;
                        state_next = ST_LOAD;
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                do_load    = 1'b1;
                idx_next   = '0;
                state_next = ST_RANK;
            end
            ST_RANK: begin
                do_rank  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT) begin
                    state_next = ST_MUL_NEW;
                end
            end
            ST_MUL_NEW: begin
                do_mul_new = 1'b1;
                state_next = ST_MUL_OLD;
            end
            ST_MUL_OLD: begin
                do_mul_old = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                do_store = 1'b1;
                if (ch_reg == CH_BLUE) begin
                    state_next = ST_EMIT;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    do_emit      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            idx_reg     <= '0;
            ch_reg      <= CH_RED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Rank unit: candidate at the head of the work line against all entries
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] lt_cnt, le_cnt;

    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            lt_cnt = lt_cnt + CNT_W'(work_reg[j] <  work_reg[0]);
            le_cnt = le_cnt + CNT_W'(work_reg[j] <= work_reg[0]);
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier and filter arithmetic
    // ------------------------------------------------------------------
    logic [ALPHA_BITS-1:0]             alpha_sat;
    logic [SAMPLE_BITS:0]              med_sum;
    logic [ALPHA_BITS-1:0]             mul_a;
    logic [SAMPLE_BITS-1:0]            mul_b;
    logic [ALPHA_BITS+SAMPLE_BITS-1:0] product;
    logic [SAMPLE_BITS-1:0]            filt;

    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign med_sum   = {1'b0, med_lo_reg} + {1'b0, med_hi_reg};
    assign mul_a     = do_mul_new ? alpha_sat : (ALPHA_ONE - alpha_sat);
    assign mul_b     = do_mul_new ? med_sum[SAMPLE_BITS:1] : prev_reg[ch_reg];
    assign product   = mul_a * mul_b;
    assign filt      = acc_reg[ALPHA_FRAC +: SAMPLE_BITS];

    // Grade the three filtered values for the result word
    logic [CODE_BITS-1:0] code;

    assign code = classify(grade_of(prev_reg[CH_RED],   low_thr_reg, high_thr_reg),
                           grade_of(prev_reg[CH_GREEN], low_thr_reg, high_thr_reg),
                           grade_of(prev_reg[CH_BLUE],  low_thr_reg, high_thr_reg));

    // Filter history: cleared by reset, updated at the end of each channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                prev_reg[c] <= '0;
            end
        end else if (do_store) begin
            prev_reg[ch_reg] <= filt;
        end
    end

    // Datapath registers: window, work line, median capture, accumulator
    always_ff @(posedge aclk) begin
        // shift the new word into the window
        if (s_fire) begin
            win_red_reg[0]   <= s_data.red_sample;
            win_green_reg[0] <= s_data.green_sample;
            win_blue_reg[0]  <= s_data.blue_sample;
            for (int j = 1; j < WINDOW_SIZE; j++) begin
                win_red_reg[j]   <= win_red_reg[j-1];
                win_green_reg[j] <= win_green_reg[j-1];
                win_blue_reg[j]  <= win_blue_reg[j-1];
            end
        end
        // copy the current channel into the work line
        if (do_load) begin
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                unique case (ch_reg)
                    CH_RED:   work_reg[j] <= win_red_reg[j];
                    CH_GREEN: work_reg[j] <= win_green_reg[j];
                    CH_BLUE:  work_reg[j] <= win_blue_reg[j];
                    default:  work_reg[j] <= win_red_reg[j];
                endcase
            end
        end
        // capture the middle values and rotate the next candidate in
        if (do_rank) begin
            if (lt_cnt <= CNT_W'(K_LO) && CNT_W'(K_LO) < le_cnt) begin
                med_lo_reg <= work_reg[0];
            end
            if (lt_cnt <= CNT_W'(K_HI) && CNT_W'(K_HI) < le_cnt) begin
                med_hi_reg <= work_reg[0];
            end
            for (int j = 0; j < WINDOW_SIZE - 1; j++) begin
                work_reg[j] <= work_reg[j+1];
            end
            work_reg[WINDOW_SIZE-1] <= work_reg[0];
        end
        // weight the new median, then add the weighted history
        if (do_mul_new) begin
            acc_reg <= ACC_BITS'(product);
        end else if (do_mul_old) begin
            acc_reg <= acc_reg + ACC_BITS'(product);
        end
        // load the result word
        if (do_emit) begin
            res_reg.color_code     <= code;
            res_reg.filtered_red   <= prev_reg[CH_RED];
            res_reg.filtered_green <= prev_reg[CH_GREEN];
            res_reg.filtered_blue  <= prev_reg[CH_BLUE];
        end
    end

`ifndef ASSERT_OFF
    // A word that completes the window starts a median run
    a_window_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && fill_reg == LAST_SLOT |=> state_reg == ST_LOAD)
        else $error("completed window did not start a median run");

    // A pending result word is never overwritten by the next run
    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && m_valid_reg && !m_ready
        |=> state_reg == ST_EMIT && $stable(res_reg))
        else $error("result word overwritten while still pending");

    // Colour codes stay within the defined set
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> res_reg.color_code <= COLOR_UNKNOWN)
        else $error("colour code out of range");

    // The rank pass leaves only after visiting every window entry
    a_rank_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_NEW |-> $past(idx_reg) == LAST_SLOT)
        else $error("rank pass ended early");
`endif

endmodule
